FILE: rtl/gtg_pkg.sv
// Shared types and constants for the go-to-goal proportional controller.
// No dependencies; every other file imports this package.
package gtg_pkg;

  localparam int XW         = 28;
  localparam int ZW         = 34;
  localparam int GUARD_BITS = 8;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [16:0]          INV_K_Q16   = 17'd39797;

  localparam logic [15:0] LIN_GAIN_RST = 16'd4915;
  localparam logic [15:0] ANG_GAIN_RST = 16'd16384;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = 4'd3;

  typedef struct packed {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
  } out_item_t;

  typedef struct packed {
    logic              vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/go_to_goal_p_controller.sv
// Go-to-goal proportional controller, fully pipelined.
// Throughput one item per cycle, set by one register stage per CORDIC
// iteration plus entry and scaling stages.
// busy is always low; out_valid strobes for one cycle per item and cannot be stalled.
// rst_n (synchronous) clears all valid bits and restores goal 0, gains 0.3 and 1.0.
// Depends on gtg_pkg, gtg_prerot, gtg_cordic_stage, gtg_scale.
module go_to_goal_p_controller #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  gtg_pkg::in_item_t                in_item,
  output logic                             out_valid,
  output gtg_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);
  import gtg_pkg::*;

  logic signed [15:0] goal_x_r;
  logic signed [15:0] goal_y_r;
  logic [15:0]        lin_gain_r;
  logic [15:0]        ang_gain_r;
  logic               in_vld;
  cordic_t            st [0:CORDIC_STAGES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_vld    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r   <= '0;
      goal_y_r   <= '0;
      lin_gain_r <= LIN_GAIN_RST;
      ang_gain_r <= ANG_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GOAL_X:       goal_x_r   <= cfg_data;
        REG_GOAL_Y:       goal_y_r   <= cfg_data;
        REG_LINEAR_GAIN:  lin_gain_r <= cfg_data;
        REG_ANGULAR_GAIN: ang_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gtg_prerot u_prerot (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_item (in_item),
    .goal_x  (goal_x_r),
    .goal_y  (goal_y_r),
    .out_st  (st[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    gtg_cordic_stage #(.IDX(i)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_st  (st[i]),
      .out_st (st[i+1])
    );
  end

  gtg_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_st        (st[CORDIC_STAGES]),
    .linear_gain  (lin_gain_r),
    .angular_gain (ang_gain_r),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

endmodule

FILE: rtl/gtg_prerot.sv
// Entry stage: position error against the goal and quarter-turn angle reduction.
// Depends on gtg_pkg.
module gtg_prerot (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  gtg_pkg::in_item_t     in_item,
  input  logic signed [15:0]    goal_x,
  input  logic signed [15:0]    goal_y,
  output gtg_pkg::cordic_t      out_st
);
  import gtg_pkg::*;

  logic signed [16:0]   ex;
  logic signed [16:0]   ey;
  logic signed [ZW-1:0] hz;
  logic signed [ZW-1:0] zneg;
  logic signed [XW-1:0] xq [0:2];
  logic signed [XW-1:0] yq [0:2];
  logic signed [ZW-1:0] zq [0:2];
  logic                 vld_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;

  always_comb begin
    ex    = {goal_x[15], goal_x} - {in_item.pose_x[15], in_item.pose_x};
    ey    = {goal_y[15], goal_y} - {in_item.pose_y[15], in_item.pose_y};
    hz    = {{(ZW-16){in_item.heading[15]}}, in_item.heading};
    zneg  = -hz;
    xq[0] = {{(XW-17-GUARD_BITS){ex[16]}}, ex, {GUARD_BITS{1'b0}}};
    yq[0] = {{(XW-17-GUARD_BITS){ey[16]}}, ey, {GUARD_BITS{1'b0}}};
    zq[0] = {zneg[ZW-18:0], 17'b0};
    for (int q = 0; q < 2; q++) begin
      if (zq[q] > HALF_PI_Q30) begin
        xq[q+1] = -yq[q];
        yq[q+1] = xq[q];
        zq[q+1] = zq[q] - HALF_PI_Q30;
      end else if (zq[q] < -HALF_PI_Q30) begin
        xq[q+1] = yq[q];
        yq[q+1] = -xq[q];
        zq[q+1] = zq[q] + HALF_PI_Q30;
      end else begin
        xq[q+1] = xq[q];
        yq[q+1] = yq[q];
        zq[q+1] = zq[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= xq[2];
    y_r <= yq[2];
    z_r <= zq[2];
  end

  assign out_st = '{vld: vld_r, x: x_r, y: y_r, z: z_r};

endmodule

FILE: rtl/gtg_cordic_stage.sv
// One registered CORDIC rotation-mode iteration with a fixed shift and angle.
// Depends on gtg_pkg.
module gtg_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gtg_pkg::cordic_t  in_st,
  output gtg_pkg::cordic_t  out_st
);
  import gtg_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = {{(ZW-30){1'b0}}, atan_q30(IDX)};

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 vld_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;

  always_comb begin
    dx = in_st.y >>> IDX;
    dy = in_st.x >>> IDX;
    if (!in_st.z[ZW-1]) begin
      x_nxt = in_st.x - dx;
      y_nxt = in_st.y + dy;
      z_nxt = in_st.z - ANGLE;
    end else begin
      x_nxt = in_st.x + dx;
      y_nxt = in_st.y - dy;
      z_nxt = in_st.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_st.vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign out_st = '{vld: vld_r, x: x_r, y: y_r, z: z_r};

endmodule

FILE: rtl/gtg_scale.sv
// Output stages: CORDIC gain compensation, velocity gains, rounding, saturation.
// Three register stages; depends on gtg_pkg.
module gtg_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gtg_pkg::cordic_t      in_st,
  input  logic [15:0]           linear_gain,
  input  logic [15:0]           angular_gain,
  output logic                  out_valid,
  output gtg_pkg::out_item_t    out_item
);
  import gtg_pkg::*;

  localparam int PW1 = XW + 17;
  localparam int CW  = PW1 - 16;
  localparam int PW2 = CW + 17;
  localparam int VW  = PW2 - 22;

  logic signed [PW1-1:0] px;
  logic signed [PW1-1:0] py;
  logic signed [CW-1:0]  cx_r;
  logic signed [CW-1:0]  cy_r;
  logic signed [PW2-1:0] qx;
  logic signed [PW2-1:0] qy;
  logic signed [VW-1:0]  vx_r;
  logic signed [VW-1:0]  vy_r;
  logic [2:0]            vld_r;
  out_item_t             out_r;
  out_item_t             out_nxt;

  function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v);
    logic signed [15:0] r;
    if (v > $signed({{(VW-15){1'b0}}, 15'h7fff})) begin
      r = 16'sh7fff;
    end else if (v < $signed({{(VW-15){1'b1}}, 15'h0})) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    px = PW1'(in_st.x) * $signed({{(PW1-17){1'b0}}, INV_K_Q16})
         + $signed(PW1'(1) <<< 15);
    py = PW1'(in_st.y) * $signed({{(PW1-17){1'b0}}, INV_K_Q16})
         + $signed(PW1'(1) <<< 15);
    qx = PW2'(cx_r) * $signed({{(PW2-16){1'b0}}, linear_gain})
         + $signed(PW2'(1) <<< 21);
    qy = PW2'(cy_r) * $signed({{(PW2-16){1'b0}}, angular_gain})
         + $signed(PW2'(1) <<< 21);
    out_nxt.linear_velocity  = sat16(vx_r);
    out_nxt.angular_velocity = sat16(vy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_st.vld};
    end
  end

  always_ff @(posedge clk) begin
    cx_r  <= px[PW1-1:16];
    cy_r  <= py[PW1-1:16];
    vx_r  <= qx[PW2-1:22];
    vy_r  <= qy[PW2-1:22];
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[2];
  assign out_item  = out_r;

endmodule
